/* design/bffa_pkg.sv */
`timescale 1ns / 1ps
// Shared types, sizes and codes for the bitmap first-free allocator.
// Used by bffa_ctrl, bffa_dpath and bitmap_first_free_allocator.
package bffa_pkg;

  // Map geometry
  localparam int BLOCK_BITS     = 8192;
  localparam int MAX_MAP_BLOCKS = 8;
  localparam int WORD_BITS      = 64;
  localparam int TOTAL_BITS     = MAX_MAP_BLOCKS * BLOCK_BITS;
  localparam int MAP_WORDS      = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W         = $clog2(MAP_WORDS);
  localparam int WORD_SHIFT     = $clog2(WORD_BITS);
  localparam int BLOCK_SHIFT    = $clog2(BLOCK_BITS);
  localparam int BLK_W          = $clog2(MAX_MAP_BLOCKS + 1);
  localparam int LIMIT_W        = $clog2(TOTAL_BITS + 1);
  localparam int POS_W          = ADDR_W + WORD_SHIFT;

  // Field widths
  localparam int NUM_W     = 16;
  localparam int KIND_W    = 2;
  localparam int WIDX_W    = 10;
  localparam int STATUS_W  = 2;
  localparam int MBLK_W    = 4;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  // Lowest-free-bit search: groups of eight bits
  localparam int GRP_N = WORD_BITS / 8;
  localparam int GRP_W = $clog2(GRP_N);

  // Configuration register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_MAP_BLOCKS     = 2'd0,
    REG_FIRST_NUMBER   = 2'd1,
    REG_HIGHEST_NUMBER = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_BAD_NUMBER = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FIND,
    S_COMMIT,
    S_FREE_WR,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    clear_wr;
    logic    capture;
    logic    scan_start;
    logic    scan_stop;
    logic    find;
    logic    commit;
    logic    free_rd;
    logic    free_wr;
    logic    load_wr;
    logic    res_set;
    status_t res_status;
    logic    out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  clear_last;
    logic  map_empty;
    logic  free_bad;
    logic  scan_hit;
    logic  scan_miss;
  } dp_stat_t;

endpackage

/* design/bitmap_first_free_allocator.sv */
`timescale 1ns / 1ps
// Bitmap first-free allocator: one item at a time, one result per item.
// Steps: load, unused kind, rejected free and zero-block allocate go from decode to the result;
// free reads, then writes back its map word; allocate scans from word 0 to the first map word
// holding a clear bit or to the last scanned word, one word read per cycle, then finds and commits.
// Throughput: the next item is accepted once the previous result sits in the output register.
// Reset: synchronous; afterwards a clearing pass zeroes all 1024 map words with in_tready low.
module bitmap_first_free_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,  // number[15:0], word_index[25:16], word_data[89:26], zero
  input  logic [1:0]  in_tuser,  // kind[1:0]
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // given_number[15:0], status[17:16], zero
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bffa_pkg::*;

  logic [MBLK_W-1:0] map_blocks_r;
  logic [NUM_W-1:0]  first_number_r;
  logic [NUM_W-1:0]  highest_number_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [NUM_W-1:0]  given_number;
  status_t           status;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_blocks_r     <= MBLK_W'(MAX_MAP_BLOCKS);
      first_number_r   <= NUM_W'(1);
      highest_number_r <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MAP_BLOCKS:     map_blocks_r     <= cfg_pwdata[MBLK_W-1:0];
        REG_FIRST_NUMBER:   first_number_r   <= cfg_pwdata[NUM_W-1:0];
        REG_HIGHEST_NUMBER: highest_number_r <= cfg_pwdata[NUM_W-1:0];
        REG_UNUSED:         ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_MAP_BLOCKS:     cfg_prdata = CFG_DW'(map_blocks_r);
      REG_FIRST_NUMBER:   cfg_prdata = CFG_DW'(first_number_r);
      REG_HIGHEST_NUMBER: cfg_prdata = CFG_DW'(highest_number_r);
      REG_UNUSED:         cfg_prdata = '0;
    endcase
  end

  bffa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bffa_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .map_blocks       (map_blocks_r),
    .first_number     (first_number_r),
    .highest_number   (highest_number_r),
    .in_kind          (kind_t'(in_tuser)),
    .in_number        (in_tdata[15:0]),
    .in_word_index    (in_tdata[25:16]),
    .in_word_data     (in_tdata[89:26]),
    .out_given_number (given_number),
    .out_status       (status)
  );

  // Pack the result
  assign out_tdata = {6'b0, status, given_number};

`ifndef SYNTHESIS
  // Reset starts the clearing pass, so no item is taken right after it
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("item accepted right after reset");

  // An accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted back to back");

  // A failed or non-allocating result carries number zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[17:16] != ST_OK) |-> (out_tdata[15:0] == '0))
    else $error("nonzero number on a failed result");

  // Status never carries the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:16] != 2'b11))
    else $error("undefined status code");
`endif

endmodule

/* design/bffa_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the allocator: sequences clear, scan, free and load.
// Depends on bffa_pkg; drives bffa_dpath through dp_cmd_t.
module bffa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  bffa_pkg::dp_stat_t stat,
  output bffa_pkg::dp_cmd_t  cmd
);
  import bffa_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = ST_OK;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.kind)
          KIND_ALLOC: begin
            if (stat.map_empty) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NO_SPACE;
              state_nxt      = S_DONE;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          KIND_FREE: begin
            if (stat.free_bad) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_BAD_NUMBER;
              state_nxt      = S_DONE;
            end else begin
              cmd.free_rd = 1'b1;
              state_nxt   = S_FREE_WR;
            end
          end
          KIND_LOAD: begin
            cmd.load_wr = 1'b1;
            cmd.res_set = 1'b1;
            state_nxt   = S_DONE;
          end
          KIND_NONE: begin
            cmd.res_set = 1'b1;
            state_nxt   = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        // Stop at the first word with a clear bit
        if (stat.scan_hit) begin
          cmd.scan_stop = 1'b1;
          state_nxt     = S_FIND;
        end else if (stat.scan_miss) begin
          cmd.scan_stop  = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NO_SPACE;
          state_nxt      = S_DONE;
        end
      end
      S_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        cmd.res_set = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

/* design/bffa_dpath.sv */
`timescale 1ns / 1ps
// Datapath of the allocator: used-map memory, scan counter, bit search and results.
// Depends on bffa_pkg; commanded by bffa_ctrl.
module bffa_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bffa_pkg::dp_cmd_t               cmd,
  output bffa_pkg::dp_stat_t              stat,
  input  logic [bffa_pkg::MBLK_W-1:0]     map_blocks,
  input  logic [bffa_pkg::NUM_W-1:0]      first_number,
  input  logic [bffa_pkg::NUM_W-1:0]      highest_number,
  input  bffa_pkg::kind_t                 in_kind,
  input  logic [bffa_pkg::NUM_W-1:0]      in_number,
  input  logic [bffa_pkg::WIDX_W-1:0]     in_word_index,
  input  logic [bffa_pkg::WORD_BITS-1:0]  in_word_data,
  output logic [bffa_pkg::NUM_W-1:0]      out_given_number,
  output bffa_pkg::status_t               out_status
);
  import bffa_pkg::*;

  // Used map
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // Captured item
  kind_t                kind_r;
  logic [NUM_W-1:0]     number_r;
  logic [WIDX_W-1:0]    widx_r;
  logic [WORD_BITS-1:0] wdata_r;

  // Clearing pass and scan
  logic [ADDR_W-1:0]    clr_addr_r;
  logic [ADDR_W-1:0]    scan_addr_r;
  logic                 scan_run_r;
  logic                 chk_valid_r;
  logic [ADDR_W-1:0]    chk_addr_r;
  logic                 chk_last_r;
  logic [WORD_BITS-1:0] hit_word_r;
  logic [ADDR_W-1:0]    hit_addr_r;
  logic [WORD_SHIFT-1:0] bit_r;

  // Results
  logic [NUM_W-1:0]     res_given_r;
  status_t              res_status_r;
  logic [NUM_W-1:0]     out_given_r;
  status_t              out_status_r;

  // Derived sizes
  logic [BLK_W-1:0]     blocks_eff;
  logic [LIMIT_W-1:0]   limit;
  logic [ADDR_W:0]      word_cnt;
  logic [ADDR_W-1:0]    last_word;
  logic [NUM_W-1:0]     free_pos;
  logic [WORD_SHIFT-1:0] free_bit;
  logic [ADDR_W-1:0]    free_addr;
  logic                 free_under;
  logic                 any_free;

  // Bit search
  logic [WORD_BITS-1:0] free_word;
  logic [GRP_N-1:0]     grp_any;
  logic [GRP_W-1:0]     grp_sel;
  logic [7:0]           grp_bits;
  logic [2:0]           bit_sel;

  // Commit
  logic [NUM_W:0]       alloc_num;
  logic                 alloc_fit;

  // Map size in blocks, bits and words
  always_comb begin
    if (map_blocks > MBLK_W'(MAX_MAP_BLOCKS)) begin
      blocks_eff = BLK_W'(MAX_MAP_BLOCKS);
    end else begin
      blocks_eff = BLK_W'(map_blocks);
    end
    limit     = LIMIT_W'(blocks_eff) << BLOCK_SHIFT;
    word_cnt  = (ADDR_W + 1)'(blocks_eff) << (BLOCK_SHIFT - WORD_SHIFT);
    last_word = word_cnt[ADDR_W-1:0] - ADDR_W'(1);
  end

  // Free range check and address
  assign free_under = (number_r < first_number);
  assign free_pos   = number_r - first_number;
  assign free_addr  = free_pos[POS_W-1:WORD_SHIFT];
  assign free_bit   = free_pos[WORD_SHIFT-1:0];

  // Lowest clear bit of the hit word: group first, then bit in group
  always_comb begin
    free_word = ~hit_word_r;
    for (int g = 0; g < GRP_N; g++) begin
      grp_any[g] = |free_word[g*8 +: 8];
    end
    grp_sel = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel = GRP_W'(g);
      end
    end
    grp_bits = free_word[{grp_sel, 3'b000} +: 8];
    bit_sel  = '0;
    for (int b = 7; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = 3'(b);
      end
    end
  end

  // Number handed out and range check
  assign alloc_num = {1'b0, first_number} + (NUM_W + 1)'({hit_addr_r, bit_r});
  assign alloc_fit = (alloc_num <= {1'b0, highest_number});

  assign any_free = |(~rdata_r);

  // Memory port selection
  always_comb begin
    rd_en   = scan_run_r || cmd.free_rd;
    rd_addr = scan_run_r ? scan_addr_r : free_addr;
    wr_en   = 1'b0;
    wr_addr = clr_addr_r;
    wr_data = '0;
    priority if (cmd.clear_wr) begin
      wr_en = 1'b1;
    end else if (cmd.load_wr) begin
      wr_en   = 1'b1;
      wr_addr = ADDR_W'(widx_r);
      wr_data = wdata_r;
    end else if (cmd.free_wr) begin
      wr_en   = 1'b1;
      wr_addr = free_addr;
      wr_data = rdata_r & ~(WORD_BITS'(1) << free_bit);
    end else if (cmd.commit && alloc_fit) begin
      wr_en   = 1'b1;
      wr_addr = hit_addr_r;
      wr_data = hit_word_r | (WORD_BITS'(1) << bit_r);
    end else begin
      wr_en = 1'b0;
    end
  end

  // Used-map memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Control counters and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      scan_addr_r <= '0;
      scan_run_r  <= 1'b0;
      chk_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_wr) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      chk_valid_r <= scan_run_r && !cmd.scan_stop;
      if (cmd.scan_start) begin
        scan_addr_r <= '0;
        scan_run_r  <= 1'b1;
      end else if (cmd.scan_stop) begin
        scan_run_r <= 1'b0;
      end else if (scan_run_r) begin
        scan_addr_r <= scan_addr_r + ADDR_W'(1);
        if (scan_addr_r == last_word) begin
          scan_run_r <= 1'b0;
        end
      end
    end
  end

  // Item capture, scan tags, search and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= in_kind;
      number_r <= in_number;
      widx_r   <= in_word_index;
      wdata_r  <= in_word_data;
    end
    chk_addr_r <= scan_addr_r;
    chk_last_r <= (scan_addr_r == last_word);
    if (cmd.scan_stop) begin
      hit_word_r <= rdata_r;
      hit_addr_r <= chk_addr_r;
    end
    if (cmd.find) begin
      bit_r <= {grp_sel, bit_sel};
    end
    if (cmd.res_set) begin
      res_given_r  <= '0;
      res_status_r <= cmd.res_status;
    end else if (cmd.commit) begin
      res_given_r  <= alloc_fit ? alloc_num[NUM_W-1:0] : '0;
      res_status_r <= alloc_fit ? ST_OK : ST_NO_SPACE;
    end
    if (cmd.out_load) begin
      out_given_r  <= res_given_r;
      out_status_r <= res_status_r;
    end
  end

  // Status to controller
  always_comb begin
    stat.kind       = kind_r;
    stat.clear_last = (clr_addr_r == ADDR_W'(MAP_WORDS - 1));
    stat.map_empty  = (blocks_eff == '0);
    stat.free_bad   = free_under || (LIMIT_W'(free_pos) >= limit);
    stat.scan_hit   = chk_valid_r && any_free;
    stat.scan_miss  = chk_valid_r && chk_last_r && !any_free;
  end

  assign out_given_number = out_given_r;
  assign out_status       = out_status_r;

endmodule

/* bench/tb_bitmap_first_free_allocator.sv */
`timescale 1ns / 1ps
// Testbench for bitmap_first_free_allocator: drives allocate, free and map-load items and
// checks every result against a first-fit bitmap predictor. Needs bffa_pkg and the RTL.
module tb_bitmap_first_free_allocator;
  import bffa_pkg::*;

  localparam int ITEM_TARGET  = 580;
  localparam int HOLD_OFF     = 300;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int FREE_SPAN    = 300;

  typedef struct packed {
    logic [NUM_W-1:0] given;
    status_t          status;
  } alloc_result_t;

  // First-fit bitmap predictor plus the queue of results still owed by the block
  class alloc_scoreboard;
    bit [WORD_BITS-1:0] used_map [MAP_WORDS];
    bit [MBLK_W-1:0]    map_blocks     = 4'd8;
    bit [NUM_W-1:0]     first_number   = 16'd1;
    bit [NUM_W-1:0]     highest_number = 16'hFFFF;
    alloc_result_t      owed_q [$];
    int errors;
    int checked;
    int no_space;
    int bad_number;

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_MAP_BLOCKS:     map_blocks     = value[MBLK_W-1:0];
        REG_FIRST_NUMBER:   first_number   = value[NUM_W-1:0];
        REG_HIGHEST_NUMBER: highest_number = value[NUM_W-1:0];
        default: ;
      endcase
    endfunction

    // Work out the result of one accepted item and queue it
    function void note_item(kind_t kind, logic [NUM_W-1:0] number, logic [WIDX_W-1:0] widx,
                            logic [WORD_BITS-1:0] data);
      alloc_result_t r;
      int blocks;
      int limit;
      int w;
      int b;
      int pos;
      r.given  = '0;
      r.status = ST_OK;
      blocks = (map_blocks > MAX_MAP_BLOCKS) ? MAX_MAP_BLOCKS : int'(map_blocks);
      limit  = blocks * BLOCK_BITS;
      case (kind)
        KIND_ALLOC: begin
          r.status = ST_NO_SPACE;
          // only the first word with a clear bit counts
          for (w = 0; w < limit / WORD_BITS; w++) begin
            if (~used_map[w] != '0) begin
              b = 0;
              while (used_map[w][b]) b++;
              pos = w * WORD_BITS + b;
              if (pos < limit && int'(first_number) + pos <= int'(highest_number)) begin
                used_map[w][b] = 1'b1;
                r.given  = 16'(int'(first_number) + pos);
                r.status = ST_OK;
              end
              break;
            end
          end
        end
        KIND_FREE: begin
          pos = int'(number) - int'(first_number);
          if (pos < 0 || pos >= limit) begin
            r.status = ST_BAD_NUMBER;
          end else begin
            used_map[pos / WORD_BITS][pos % WORD_BITS] = 1'b0;
          end
        end
        KIND_LOAD: begin
          used_map[widx] = data;
        end
        default: ;
      endcase
      if (r.status == ST_NO_SPACE) no_space++;
      if (r.status == ST_BAD_NUMBER) bad_number++;
      owed_q.insert(owed_q.size(), r);
    endfunction

    // Compare one result with the oldest owed result
    function void check_result(logic [23:0] tdata);
      alloc_result_t want;
      logic [NUM_W-1:0]    got_num;
      logic [STATUS_W-1:0] got_st;
      got_num = tdata[15:0];
      got_st  = tdata[17:16];
      if (owed_q.size() == 0) begin
        $error("unexpected result: given_number %0d status %0d", got_num, got_st);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (got_num !== want.given) begin
        $error("given_number: expected %0d, actual %0d", want.given, got_num);
        errors++;
      end
      if (got_st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got_st);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;  // number[15:0], word_index[25:16], word_data[89:26], zero
  logic [1:0]  in_tuser;  // kind[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata; // given_number[15:0], status[17:16], zero
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  alloc_scoreboard sb = new();

  bit               steady;
  bit               hold_req;
  int               items_sent;
  int               setups;
  int               cycles;
  logic [NUM_W-1:0] cur_first;

  bitmap_first_free_allocator uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle limit
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Offer one item, maybe after a random gap; returns at the falling edge after acceptance
  task automatic send_item(input kind_t kind, input logic [NUM_W-1:0] number,
                           input logic [WIDX_W-1:0] widx, input logic [WORD_BITS-1:0] data);
    if (!steady) begin
      while ($urandom_range(99) < 34) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, data, widx, number};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(kind, number, widx, data);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every owed result is back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one register, then read it back
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] readback;
    mask = (idx == REG_MAP_BLOCKS) ? 32'hF : 32'hFFFF;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk) cfg_penable <= 1'b1;
    @(negedge clk) begin
      cfg_pwrite  <= 1'b0;
      cfg_penable <= 1'b0;
    end
    @(negedge clk) cfg_penable <= 1'b1;
    @(posedge clk) readback = cfg_prdata;
    @(negedge clk) begin
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
    end
    sb.write_reg(idx, value);
    if (readback !== (value & mask)) begin
      $error("%s: expected %0d, actual %0d", idx.name(), value & mask, readback);
      sb.errors++;
    end
  endtask

  task automatic setup(input logic [MBLK_W-1:0] blocks, input logic [NUM_W-1:0] first,
                       input logic [NUM_W-1:0] highest);
    wait_idle();
    write_reg(REG_MAP_BLOCKS, 32'(blocks));
    write_reg(REG_FIRST_NUMBER, 32'(first));
    write_reg(REG_HIGHEST_NUMBER, 32'(highest));
    cur_first = first;
    setups++;
  endtask

  // Mostly allocate/free traffic near the allocation front, plus loads and noise
  task automatic random_item();
    int                   sel;
    kind_t                kind;
    logic [NUM_W-1:0]     number;
    logic [WIDX_W-1:0]    widx;
    logic [WORD_BITS-1:0] data;
    sel    = $urandom_range(99);
    number = 16'($urandom);
    widx   = 10'($urandom);
    data   = {$urandom, $urandom};
    if (sel < 45) begin
      kind = KIND_ALLOC;
    end else if (sel < 75) begin
      kind   = KIND_FREE;
      number = 16'(int'(cur_first) + $urandom_range(0, FREE_SPAN));
    end else if (sel < 83) begin
      kind = KIND_LOAD;
      widx = 10'($urandom_range(0, 3));
    end else if (sel < 88) begin
      kind = KIND_LOAD;
    end else if (sel < 94) begin
      kind = KIND_FREE;
    end else begin
      kind = KIND_NONE;
    end
    send_item(kind, number, widx, data);
  endtask

  task automatic random_setup();
    logic [MBLK_W-1:0] blocks;
    logic [NUM_W-1:0]  first;
    logic [NUM_W-1:0]  highest;
    int                pick;
    pick = $urandom_range(9);
    if (pick == 0) blocks = 4'd0;
    else if (pick == 1) blocks = 4'd15;
    else if (pick < 4) blocks = 4'd1;
    else if (pick < 6) blocks = 4'd8;
    else blocks = 4'($urandom_range(1, 8));
    pick = $urandom_range(9);
    if (pick == 0) first = 16'd0;
    else if (pick == 1) first = 16'hFFFF;
    else if (pick == 2) first = 16'(65535 - $urandom_range(0, 300));
    else first = 16'($urandom_range(0, 200));
    pick = $urandom_range(9);
    if (pick == 0) highest = 16'd0;
    else if (pick < 6) highest = 16'hFFFF;
    else if (pick < 8) begin
      pick    = int'(first) + $urandom_range(0, 150);
      highest = (pick > 65535) ? 16'hFFFF : 16'(pick);
    end else highest = 16'($urandom);
    setup(blocks, first, highest);
  endtask

  // Fill one whole block, then work at its edges
  task automatic fill_one_block();
    int w;
    setup(4'd1, 16'd1, 16'hFFFF);
    for (w = 0; w < BLOCK_BITS / WORD_BITS; w++) begin
      send_item(KIND_LOAD, 16'($urandom), 10'(w), '1);
    end
    send_item(KIND_ALLOC, 16'($urandom), 10'($urandom), {$urandom, $urandom});
    send_item(KIND_FREE, 16'd1, 10'd0, '0);
    send_item(KIND_FREE, 16'(BLOCK_BITS), 10'd0, '0);
    send_item(KIND_FREE, 16'(BLOCK_BITS + 1), 10'd0, '0);
    repeat (3) send_item(KIND_ALLOC, 16'd0, 10'd0, '0);
  endtask

  initial begin
    int phase;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    steady      = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    setups      = 0;
    cur_first   = 16'd1;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // let the clearing pass finish
    @(negedge clk);
    while (!in_tready) @(negedge clk);

    // Directed: defaults, reuse of freed bits, frees below and at the top of the map
    setup(4'd8, 16'd1, 16'hFFFF);
    send_item(KIND_ALLOC, 16'd0, 10'd0, '0);
    send_item(KIND_ALLOC, 16'd0, 10'd0, '0);
    send_item(KIND_FREE, 16'd1, 10'd0, '0);
    send_item(KIND_FREE, 16'd1, 10'd0, '0);
    send_item(KIND_ALLOC, 16'd0, 10'd0, '0);
    send_item(KIND_FREE, 16'd0, 10'd0, '0);
    send_item(KIND_FREE, 16'hFFFF, 10'd0, '0);
    send_item(KIND_LOAD, 16'd0, 10'd0, '1);
    send_item(KIND_ALLOC, 16'd0, 10'd0, '0);
    send_item(KIND_LOAD, 16'd0, 10'h3FF, '1);
    send_item(KIND_LOAD, 16'hFFFF, 10'h3FF, '0);
    send_item(KIND_NONE, 16'hFFFF, 10'h3FF, '1);
    // Zero map blocks: nothing to scan, every free is bad
    setup(4'd0, 16'd1, 16'hFFFF);
    send_item(KIND_ALLOC, 16'd0, 10'd0, '0);
    send_item(KIND_FREE, 16'd1, 10'd0, '0);
    // Block count above the maximum clamps to the full map
    setup(4'd15, 16'd0, 16'hFFFF);
    send_item(KIND_FREE, 16'hFFFF, 10'd0, '0);
    send_item(KIND_ALLOC, 16'd0, 10'd0, '0);
    // Numbers run past 65535
    setup(4'd8, 16'd65530, 16'hFFFF);
    send_item(KIND_LOAD, 16'd0, 10'd0, '0);
    repeat (7) send_item(KIND_ALLOC, 16'd0, 10'd0, '0);
    // Highest number below the first one
    setup(4'd8, 16'd1, 16'd0);
    send_item(KIND_ALLOC, 16'd0, 10'd0, '0);

    // Random phases
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 4) begin
        steady = 1'b0;
        fill_one_block();
      end else begin
        random_setup();
        steady = (phase == 1);
        if (phase == 2) hold_req = 1'b1;
        repeat ($urandom_range(40, 70)) random_item();
      end
      phase++;
    end
    steady = 1'b0;
    wait_idle();
    repeat (20) @(negedge clk);

    if (sb.outstanding() != 0) begin
      $error("%0d results never arrived", sb.outstanding());
      sb.errors++;
    end
    $display("Drove %0d items over %0d setups, one full-block scan; %0d results checked.",
             items_sent, setups, sb.checked);
    $display("Saw %0d out-of-space and %0d bad-number outcomes in %0d cycles.",
             sb.no_space, sb.bad_number, cycles);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
design/bffa_pkg.sv
design/bffa_ctrl.sv
design/bffa_dpath.sv
design/bitmap_first_free_allocator.sv
bench/tb_bitmap_first_free_allocator.sv
